### rtl/lmdr_pkg.sv
package lmdr_pkg;

    localparam int TIME_W       = 18;
    localparam int LEVEL_W      = 8;
    localparam int NUM_CHANNELS = 4;

    // Light modes, also the encoding of the mode result field.
    typedef enum logic [1:0] {
        MODE_AUTO    = 2'd0,
        MODE_MANUAL  = 2'd1,
        MODE_BATTERY = 2'd2
    } mode_t;

    // Request operations; the unused fourth code behaves as a poll.
    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_KEY  = 2'd1,
        OP_POLL = 2'd2
    } op_t;

    // Bit positions inside keys_pressed.
    localparam int KEY_UP    = 0;
    localparam int KEY_DOWN  = 1;
    localparam int KEY_COLOR = 2;
    localparam int KEY_MODE  = 3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_RAMP_UP_END     = 2'd0;
    localparam logic [1:0] CFG_RAMP_DOWN_START = 2'd1;
    localparam logic [1:0] CFG_RAMP_DOWN_END   = 2'd2;

    localparam logic [TIME_W-1:0] RAMP_UP_END_RST     = 18'd35000;
    localparam logic [TIME_W-1:0] RAMP_DOWN_START_RST = 18'd100000;
    localparam logic [TIME_W-1:0] RAMP_DOWN_END_RST   = 18'd135000;

    // The ramp index is floor(d / 137), saturated at 255. Any dividend at or
    // above 255 * 137 saturates; below that, a multiply by ceil(2^23 / 137)
    // and a shift by 23 gives the exact quotient.
    localparam logic [TIME_W-1:0] RAMP_SAT_LIMIT = 18'd34935;
    localparam logic [15:0]       RAMP_RECIP     = 16'd61231;
    localparam int                RAMP_SHIFT     = 23;

    typedef struct packed {
        logic [TIME_W-1:0] up_end;
        logic [TIME_W-1:0] down_start;
        logic [TIME_W-1:0] down_end;
    } ramp_cfg_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [3:0] keys_pressed;
        logic       power_good;
    } in_item_t;

    typedef struct packed {
        mode_t              mode;
        logic               channels_on;
        logic [LEVEL_W-1:0] color_index;
        logic [LEVEL_W-1:0] lamp_level;
        logic [LEVEL_W-1:0] red_level;
        logic [LEVEL_W-1:0] green_level;
        logic [LEVEL_W-1:0] blue_level;
        logic [1:0]         selected_channel;
        logic [4:0]         hour;
        logic [5:0]         minute;
        logic [5:0]         second;
    } out_item_t;

endpackage

### rtl/lmdr_ramp.sv
module lmdr_ramp (
    input  logic [lmdr_pkg::TIME_W-1:0]  scaled_time,
    input  lmdr_pkg::ramp_cfg_t          cfg,
    output logic [lmdr_pkg::LEVEL_W-1:0] index
);
    import lmdr_pkg::*;

    typedef enum logic [1:0] {
        SEL_UP,
        SEL_FULL,
        SEL_DOWN,
        SEL_NIGHT
    } ramp_sel_t;

    ramp_sel_t         sel;
    logic [TIME_W-1:0] dividend;
    logic [31:0]       product;

    // Later segments win where configured windows overlap.
    always_comb
    begin
        priority if (scaled_time > cfg.down_end)
            sel = SEL_NIGHT;
        else if (scaled_time >= cfg.down_start)
            sel = SEL_DOWN;
        else if (scaled_time > cfg.up_end)
            sel = SEL_FULL;
        else
            sel = SEL_UP;
    end

    assign dividend = (sel == SEL_DOWN) ? (cfg.down_end - scaled_time) : scaled_time;
    assign product  = dividend[15:0] * RAMP_RECIP;

    always_comb
    begin
        unique case (sel)
            SEL_UP, SEL_DOWN:
            begin
                if (dividend >= RAMP_SAT_LIMIT)
                    index = '1;
                else
                    index = product[RAMP_SHIFT +: LEVEL_W];
            end
            SEL_FULL:  index = '1;
            SEL_NIGHT: index = '0;
            default:   index = '0;
        endcase
    end

endmodule

### rtl/lmdr_core.sv
module lmdr_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  step,
    input  lmdr_pkg::in_item_t    item,
    input  lmdr_pkg::ramp_cfg_t   cfg,
    output lmdr_pkg::out_item_t   result_next
);
    import lmdr_pkg::*;

    logic [4:0]         hour_reg,   hour_next;
    logic [5:0]         minute_reg, minute_next;
    logic [5:0]         second_reg, second_next;
    logic [TIME_W-1:0]  scaled_time_reg, scaled_time_next;
    logic [3:0]         scaled_rem_reg,  scaled_rem_next;
    mode_t              mode_reg, mode_next, mode_keyed;
    logic [1:0]         channel_reg, channel_next;
    logic [LEVEL_W-1:0] level_reg  [NUM_CHANNELS];
    logic [LEVEL_W-1:0] level_next [NUM_CHANNELS];

    logic               tick, key_op, day_wrap;
    logic               level_up, level_down;
    logic [LEVEL_W-1:0] ramp_index;

    assign tick   = (item.operation == OP_TICK);
    assign key_op = (item.operation == OP_KEY);

    // Time of day. The scaled time is floor(seconds_of_day * 25 / 9), kept
    // with its remainder so that each second adds two or three.
    assign day_wrap = (hour_reg == 5'd23) && (minute_reg == 6'd59) && (second_reg == 6'd59);

    always_comb
    begin
        hour_next        = hour_reg;
        minute_next      = minute_reg;
        second_next      = second_reg;
        scaled_time_next = scaled_time_reg;
        scaled_rem_next  = scaled_rem_reg;
        if (tick)
        begin
            if (second_reg == 6'd59)
            begin
                second_next = '0;
                if (minute_reg == 6'd59)
                begin
                    minute_next = '0;
                    hour_next   = (hour_reg == 5'd23) ? 5'd0 : hour_reg + 5'd1;
                end
                else
                    minute_next = minute_reg + 6'd1;
            end
            else
                second_next = second_reg + 6'd1;

            if (day_wrap)
            begin
                scaled_time_next = '0;
                scaled_rem_next  = '0;
            end
            else if (scaled_rem_reg >= 4'd2)
            begin
                scaled_time_next = scaled_time_reg + TIME_W'(3);
                scaled_rem_next  = scaled_rem_reg - 4'd2;
            end
            else
            begin
                scaled_time_next = scaled_time_reg + TIME_W'(2);
                scaled_rem_next  = scaled_rem_reg + 4'd7;
            end
        end
    end

    // Key handling, then the power check, decide the next mode.
    always_comb
    begin
        mode_keyed   = mode_reg;
        channel_next = channel_reg;
        level_up     = 1'b0;
        level_down   = 1'b0;
        if (key_op)
        begin
            unique case (mode_reg)
                MODE_AUTO:
                begin
                    if (item.keys_pressed[KEY_MODE])
                        mode_keyed = MODE_MANUAL;
                end
                MODE_MANUAL:
                begin
                    priority if (item.keys_pressed[KEY_MODE])
                        mode_keyed = MODE_AUTO;
                    else if (item.keys_pressed[KEY_COLOR])
                        channel_next = channel_reg + 2'd1;
                    else if (item.keys_pressed[KEY_DOWN])
                        level_down = 1'b1;
                    else if (item.keys_pressed[KEY_UP])
                        level_up = 1'b1;
                    else
                        level_up = 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (mode_keyed)
            MODE_AUTO, MODE_MANUAL:
                mode_next = item.power_good ? mode_keyed : MODE_BATTERY;
            MODE_BATTERY:
                mode_next = item.power_good ? MODE_AUTO : MODE_BATTERY;
            default:
                mode_next = MODE_AUTO;
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            level_next[i] = level_reg[i];
            if (channel_reg == 2'(i))
            begin
                if (level_down)
                    level_next[i] = level_reg[i] - LEVEL_W'(1);
                else if (level_up)
                    level_next[i] = level_reg[i] + LEVEL_W'(1);
            end
        end
    end

    lmdr_ramp u_ramp (
        .scaled_time (scaled_time_next),
        .cfg         (cfg),
        .index       (ramp_index)
    );

    // Result fields for the state this request leaves behind.
    always_comb
    begin
        result_next.mode             = mode_next;
        result_next.channels_on      = (mode_next != MODE_BATTERY);
        result_next.color_index      = '0;
        result_next.lamp_level       = '0;
        result_next.red_level        = '0;
        result_next.green_level      = '0;
        result_next.blue_level       = '0;
        result_next.selected_channel = channel_next;
        result_next.hour             = hour_next;
        result_next.minute           = minute_next;
        result_next.second           = second_next;
        unique case (mode_next)
            MODE_AUTO:
            begin
                result_next.color_index = ramp_index;
                result_next.lamp_level  = ~ramp_index;
            end
            MODE_MANUAL:
            begin
                result_next.red_level   = ~level_next[0];
                result_next.green_level = ~level_next[1];
                result_next.blue_level  = ~level_next[2];
                result_next.lamp_level  = ~level_next[3];
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hour_reg        <= '0;
            minute_reg      <= '0;
            second_reg      <= '0;
            scaled_time_reg <= '0;
            scaled_rem_reg  <= '0;
            mode_reg        <= MODE_AUTO;
            channel_reg     <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++)
                level_reg[i] <= '0;
        end
        else if (step)
        begin
            hour_reg        <= hour_next;
            minute_reg      <= minute_next;
            second_reg      <= second_next;
            scaled_time_reg <= scaled_time_next;
            scaled_rem_reg  <= scaled_rem_next;
            mode_reg        <= mode_next;
            channel_reg     <= channel_next;
            for (int i = 0; i < NUM_CHANNELS; i++)
                level_reg[i] <= level_next[i];
        end
    end

endmodule

### rtl/light_mode_and_daylight_ramp.sv
// Channel   Handshake                Payload
// item      item_valid / item_ready  item (operation, keys_pressed, power_good)
// result    result_valid / result_ready  result (mode, levels, channel, clock)
// config    cfg_valid / cfg_ready    cfg_index, cfg_data (ramp time limits)
//
// Each request produces exactly one result: the accepted request sits in the
// input register, and the evaluation loads the result register from it
// when the result side can take it. A new request is accepted every cycle
// while the result is not stalled; the single evaluation pass between the
// two registers sets that rate.
// Reset clears the clock, the mode (auto), the selected channel, the manual
// levels and the valid flags of both pipeline registers, and loads the default
// ramp limits.
// A stalled result holds the pipeline; the input register still takes one
// request while the result waits. Configuration writes are taken at once.
module light_mode_and_daylight_ramp (
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 item_valid,
    output logic                 item_ready,
    input  lmdr_pkg::in_item_t   item,

    output logic                 result_valid,
    input  logic                 result_ready,
    output lmdr_pkg::out_item_t  result,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [lmdr_pkg::TIME_W-1:0] cfg_data
);
    import lmdr_pkg::*;

    ramp_cfg_t  cfg_reg;
    in_item_t   item_reg;
    logic       item_valid_reg;
    out_item_t  result_reg;
    out_item_t  result_next;
    logic       result_valid_reg;
    logic       advance;
    logic       step;

    // The result register can load when it is empty or being drained.
    assign advance    = !result_valid_reg || result_ready;
    assign step       = item_valid_reg && advance;
    assign item_ready = !item_valid_reg || advance;
    assign cfg_ready  = 1'b1;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Ramp limit registers. Writes to the unused index are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.up_end     <= RAMP_UP_END_RST;
            cfg_reg.down_start <= RAMP_DOWN_START_RST;
            cfg_reg.down_end   <= RAMP_DOWN_END_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_RAMP_UP_END:     cfg_reg.up_end     <= cfg_data;
                CFG_RAMP_DOWN_START: cfg_reg.down_start <= cfg_data;
                CFG_RAMP_DOWN_END:   cfg_reg.down_end   <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register: holds one request while the result side is stalled.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else if (item_ready)
            item_valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
            item_reg <= item;
    end

    // The core updates its state on the same edge the result is registered.
    lmdr_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .item        (item_reg),
        .cfg         (cfg_reg),
        .result_next (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (step)
            result_valid_reg <= 1'b1;
        else if (result_ready)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            result_reg <= result_next;
    end

    // A request that is evaluated always leaves a result behind.
    assert property (@(posedge clk) disable iff (!rst_n)
        step |=> result_valid)
        else $error("evaluated request produced no result");

    // A held request must not change while the result side stalls.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && !advance) |=> (item_valid_reg && $stable(item_reg)))
        else $error("held request lost or changed during stall");

    // Lights are enabled exactly when not on battery.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.channels_on == (result.mode != MODE_BATTERY)))
        else $error("channel enable disagrees with mode");

    // The ramp index is only given out in auto mode.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.mode != MODE_AUTO) |-> (result.color_index == '0))
        else $error("color index outside auto mode");

endmodule

### bench/tb_light_mode_and_daylight_ramp.sv
`timescale 1ns / 1ps

module tb_light_mode_and_daylight_ramp;
    import lmdr_pkg::*;

    // The fourth operation code has no name in the package; the block treats it as a poll.
    localparam logic [1:0] OP_UNUSED = 2'd3;
    // Register index that maps to no register; a write to it must change nothing.
    localparam logic [1:0] CFG_UNMAPPED = 2'd3;
    localparam int unsigned TIME_MAX = 239999;
    localparam int unsigned RAMP_DIVISOR = 137;
    localparam int MAX_REPORTED = 10;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic item_valid = 1'b0;
    logic item_ready;
    in_item_t req_item = '0;

    logic result_valid;
    logic result_ready = 1'b0;
    out_item_t res_item;

    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [TIME_W-1:0] cfg_data = '0;

    light_mode_and_daylight_ramp u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (req_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (res_item),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // Requests waiting to be driven, and the light outputs each accepted request must produce.
    in_item_t pending_requests[$];
    out_item_t expected_lights[$];

    // Percent of cycles in which the sender holds back a request or the receiver is not ready.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int mismatches = 0;
    int results_seen = 0;
    logic drain_wait = 1'b0;

    // Shadow of the controller: ramp limits, day clock, mode, channel pointer and manual
    // levels, all starting from their reset values.
    ramp_cfg_t ramp = '{RAMP_UP_END_RST, RAMP_DOWN_START_RST, RAMP_DOWN_END_RST};
    logic [4:0] day_hour = '0;
    logic [5:0] day_minute = '0;
    logic [5:0] day_second = '0;
    mode_t light_mode = MODE_AUTO;
    logic [1:0] channel_ptr = '0;
    logic [LEVEL_W-1:0] manual_level [NUM_CHANNELS] = '{default: '0};

    // Scaled time of day: seconds * 25 / 9 equals hours * 10000 plus the fractional hour.
    function automatic int unsigned scaled_now();
        int unsigned secs;
        secs = day_hour * 3600 + day_minute * 60 + day_second;
        return secs * 25 / 9;
    endfunction

    function automatic logic [7:0] saturate_index(input int unsigned q);
        return (q > 255) ? 8'd255 : q[7:0];
    endfunction

    // The ramp cases are evaluated in order and the last one that matches wins. With
    // unordered limits more than one can match.
    function automatic logic [7:0] daylight_index();
        int unsigned t;
        logic [7:0] idx;
        t = scaled_now();
        idx = '0;
        if (t <= ramp.up_end)
            idx = saturate_index(t / RAMP_DIVISOR);
        if (t > ramp.up_end && t < ramp.down_start)
            idx = 8'd255;
        if (t >= ramp.down_start && t <= ramp.down_end)
            idx = saturate_index((ramp.down_end - t) / RAMP_DIVISOR);
        if (t > ramp.down_end)
            idx = '0;
        return idx;
    endfunction

    // Advances the shadow state by one request and returns the light outputs it produces.
    function automatic out_item_t predict_light(input in_item_t req);
        out_item_t res;
        logic [7:0] idx;
        res = '0;
        if (req.operation == OP_KEY)
        begin
            // Battery mode ignores every key.
            if (light_mode == MODE_AUTO)
            begin
                if (req.keys_pressed[KEY_MODE])
                    light_mode = MODE_MANUAL;
            end
            else if (light_mode == MODE_MANUAL)
            begin
                // Priority: mode, then color, then down, then up.
                if (req.keys_pressed[KEY_MODE])
                    light_mode = MODE_AUTO;
                else if (req.keys_pressed[KEY_COLOR])
                    channel_ptr = channel_ptr + 2'd1;
                else if (req.keys_pressed[KEY_DOWN])
                    manual_level[channel_ptr] = manual_level[channel_ptr] - 8'd1;
                else if (req.keys_pressed[KEY_UP])
                    manual_level[channel_ptr] = manual_level[channel_ptr] + 8'd1;
            end
        end
        if (req.operation == OP_TICK)
        begin
            day_second = day_second + 6'd1;
            if (day_second >= 60)
            begin
                day_second = '0;
                day_minute = day_minute + 6'd1;
            end
            if (day_minute >= 60)
            begin
                day_minute = '0;
                day_hour = day_hour + 5'd1;
            end
            if (day_hour >= 24)
                day_hour = '0;
        end
        // Power loss drops to battery at once; power return goes straight to auto.
        if ((light_mode == MODE_AUTO || light_mode == MODE_MANUAL) && !req.power_good)
            light_mode = MODE_BATTERY;
        else if (light_mode == MODE_BATTERY && req.power_good)
            light_mode = MODE_AUTO;

        if (light_mode == MODE_AUTO)
        begin
            idx = daylight_index();
            res.color_index = idx;
            res.lamp_level = ~idx;
        end
        else if (light_mode == MODE_MANUAL)
        begin
            res.red_level = ~manual_level[0];
            res.green_level = ~manual_level[1];
            res.blue_level = ~manual_level[2];
            res.lamp_level = ~manual_level[3];
        end
        res.mode = light_mode;
        res.channels_on = (light_mode != MODE_BATTERY);
        res.selected_channel = channel_ptr;
        res.hour = day_hour;
        res.minute = day_minute;
        res.second = day_second;
        return res;
    endfunction

    // Driver: pushes the expectation for a request at the edge where it is accepted, then
    // decides whether to present the next one. Valid holds with a stable request while
    // the block stalls. Now and then the sender pauses until every result has arrived.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else
        begin
            if (item_valid && item_ready)
                expected_lights.push_back(predict_light(req_item));
            if (!(item_valid && !item_ready))
            begin
                if (drain_wait && expected_lights.size() == 0)
                    drain_wait = 1'b0;
                if (!drain_wait && pending_requests.size() != 0 && $urandom_range(0, 99) == 0)
                    drain_wait = 1'b1;
                if (!drain_wait && pending_requests.size() != 0
                    && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    req_item <= pending_requests.pop_front();
                    item_valid <= 1'b1;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= MAX_REPORTED)
                $display("result %0d: %s expected %0d, got %0d", results_seen, name, want, got);
        end
    endtask

    // Monitor: compares each accepted result with the oldest expectation, field by field,
    // and drives a randomly stalling ready.
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_lights.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTED)
                        $display("result %0d arrived with no request outstanding", results_seen);
                end
                else
                begin
                    want = expected_lights.pop_front();
                    check_field("mode", want.mode, res_item.mode);
                    check_field("channels_on", want.channels_on, res_item.channels_on);
                    check_field("color_index", want.color_index, res_item.color_index);
                    check_field("lamp_level", want.lamp_level, res_item.lamp_level);
                    check_field("red_level", want.red_level, res_item.red_level);
                    check_field("green_level", want.green_level, res_item.green_level);
                    check_field("blue_level", want.blue_level, res_item.blue_level);
                    check_field("selected_channel", want.selected_channel,
                                res_item.selected_channel);
                    check_field("hour", want.hour, res_item.hour);
                    check_field("minute", want.minute, res_item.minute);
                    check_field("second", want.second, res_item.second);
                end
                results_seen++;
            end
            result_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    task automatic push_req(input logic [1:0] op, input logic [3:0] keys, input logic pg);
        in_item_t req;
        req.operation = op;
        req.keys_pressed = keys;
        req.power_good = pg;
        pending_requests.push_back(req);
    endtask

    // Mostly legal key traffic with mains present, so manual mode is reached and the levels
    // move; key bits on ticks and polls are noise that the block must ignore.
    function automatic in_item_t random_request();
        in_item_t req;
        int pick;
        pick = $urandom_range(0, 99);
        req.operation = (pick < 40) ? OP_TICK : (pick < 80) ? OP_KEY :
                        (pick < 95) ? OP_POLL : OP_UNUSED;
        req.keys_pressed = '0;
        pick = $urandom_range(0, 99);
        if (req.operation != OP_KEY || pick >= 75)
            req.keys_pressed = 4'($urandom_range(0, 15));
        else if (pick < 50)
            req.keys_pressed[$urandom_range(0, 1) ? KEY_UP : KEY_DOWN] = 1'b1;
        else if (pick < 65)
            req.keys_pressed[KEY_COLOR] = 1'b1;
        else
            req.keys_pressed[KEY_MODE] = 1'b1;
        req.power_good = ($urandom_range(0, 99) < 93);
        return req;
    endfunction

    task automatic queue_random(input int count);
        repeat (count)
            pending_requests.push_back(random_request());
    endtask

    // Blocks until every request has been sent and every result has come back. The check
    // runs at the falling edge, after the driver and the monitor have settled.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_requests.size() != 0 || item_valid || expected_lights.size() != 0);
    endtask

    // Leaves cfg_valid high on return so that back-to-back writes never lower and raise it
    // in the same step; the caller lowers it after the last write.
    task automatic write_reg(input logic [1:0] idx, input logic [TIME_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_RAMP_UP_END:     ramp.up_end = data;
            CFG_RAMP_DOWN_START: ramp.down_start = data;
            CFG_RAMP_DOWN_END:   ramp.down_end = data;
            default:             ;
        endcase
    endtask

    task automatic set_ramp(input int unsigned up_end, input int unsigned down_start,
                            input int unsigned down_end);
        write_reg(CFG_RAMP_UP_END, up_end[TIME_W-1:0]);
        write_reg(CFG_RAMP_DOWN_START, down_start[TIME_W-1:0]);
        write_reg(CFG_RAMP_DOWN_END, down_end[TIME_W-1:0]);
        cfg_valid <= 1'b0;
    endtask

    function automatic int unsigned clip_time(input int unsigned t);
        return (t > TIME_MAX) ? TIME_MAX : t;
    endfunction

    initial
    begin
        int unsigned base;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Tight ramp limits let a few ticks cross the morning ramp,
        // the plateau and the start of the evening ramp.
        send_idle_pct = 14;
        recv_idle_pct = 57;
        set_ramp(5, 12, 290);
        push_req(OP_POLL, 4'b0000, 1'b1);
        push_req(OP_TICK, 4'b0000, 1'b1);
        push_req(OP_TICK, 4'b1111, 1'b1);
        push_req(OP_TICK, 4'b0000, 1'b1);
        push_req(OP_KEY, 4'b1000, 1'b1);
        push_req(OP_KEY, 4'b0001, 1'b1);
        // Two downs from one wrap the red level below zero.
        push_req(OP_KEY, 4'b0010, 1'b1);
        push_req(OP_KEY, 4'b0010, 1'b1);
        push_req(OP_KEY, 4'b0100, 1'b1);
        // Color beats down, and down beats up.
        push_req(OP_KEY, 4'b0110, 1'b1);
        push_req(OP_KEY, 4'b0011, 1'b1);
        push_req(OP_KEY, 4'b0100, 1'b1);
        push_req(OP_KEY, 4'b0001, 1'b1);
        // The channel pointer wraps from lamp back to red.
        push_req(OP_KEY, 4'b0100, 1'b1);
        push_req(OP_TICK, 4'b0000, 1'b1);
        // Mode beats every other key.
        push_req(OP_KEY, 4'b1111, 1'b1);
        push_req(OP_KEY, 4'b0111, 1'b1);
        push_req(OP_KEY, 4'b0000, 1'b1);
        // Power loss in auto, keys ignored on battery, then power return.
        push_req(OP_POLL, 4'b0000, 1'b0);
        push_req(OP_KEY, 4'b1000, 1'b0);
        push_req(OP_TICK, 4'b0000, 1'b0);
        push_req(OP_POLL, 4'b0000, 1'b1);
        // Power loss from manual, carried by the unused operation code.
        push_req(OP_KEY, 4'b1000, 1'b1);
        push_req(OP_UNUSED, 4'b0000, 1'b0);
        push_req(OP_UNUSED, 4'b0000, 1'b1);
        wait_idle();

        // Random part, first setting: limits placed just ahead of the current time of day.
        base = scaled_now();
        set_ramp(clip_time(base + $urandom_range(0, 400)), clip_time(base + $urandom_range(200, 900)),
                 clip_time(base + $urandom_range(500, 1500)));
        queue_random(150);
        wait_idle();

        // Swap the idling and go to the extremes. Limits of 0, 0 and the maximum keep the
        // evening ramp saturated; a write to the unmapped index must change nothing.
        send_idle_pct = 57;
        recv_idle_pct = 14;
        write_reg(CFG_UNMAPPED, TIME_MAX[TIME_W-1:0]);
        set_ramp(0, 0, TIME_MAX);
        queue_random(100);
        wait_idle();
        set_ramp(TIME_MAX, TIME_MAX, TIME_MAX);
        queue_random(100);
        wait_idle();
        set_ramp(0, 0, 0);
        queue_random(50);
        wait_idle();

        // No idling. Unordered limits near the current time test which ramp case wins.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        base = scaled_now();
        set_ramp(clip_time(base + $urandom_range(0, 1500)), clip_time(base + $urandom_range(0, 1500)),
                 clip_time(base + $urandom_range(0, 1500)));
        queue_random(200);
        wait_idle();

        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_lights.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial
    begin
        #(10_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
